/* rtl/mtda_pkg.sv */
// shared types and constants for the monochrome text display adapter
// no dependencies; imported by the top level

package mtda_pkg;

    // operation codes carried in tuser
    localparam logic [2:0] F_MEM_RD   = 3'd0;
    localparam logic [2:0] F_MEM_WR   = 3'd1;
    localparam logic [2:0] F_PORT_IN  = 3'd2;
    localparam logic [2:0] F_PORT_OUT = 3'd3;
    localparam logic [2:0] F_INVAL    = 3'd4;
    localparam logic [2:0] F_SCAN     = 3'd5;

    // bus window and port offsets
    localparam logic [19:0] BASE_ADDR   = 20'hB0000;
    localparam logic [3:0]  PORT_MODE   = 4'd8;
    localparam logic [3:0]  PORT_STATUS = 4'd10;

    // crt controller register indexes
    localparam logic [7:0] CRT_CURSOR_START = 8'h0A;
    localparam logic [7:0] CRT_CURSOR_HI    = 8'h0E;
    localparam logic [7:0] CRT_CURSOR_LO    = 8'h0F;

    localparam logic [7:0]  STATUS_TOGGLE = 8'h09;
    localparam logic [7:0]  BLANK_CHAR    = 8'h20;
    localparam logic [7:0]  ATTR_MASK     = 8'h77;
    localparam logic [7:0]  ATTR_INVERSE  = 8'h70;
    localparam logic [11:0] CURSOR_HIDDEN = 12'hFFF;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_MARK
    } t_state;

endpackage

/* rtl/mtda_ram.sv */
// simple dual-port memory: one write and one registered read per cycle
// no dependencies; holds the dirty marks and the crt registers

module mtda_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/mtda_vram.sv */
// display memory as 16-bit cells (character low, attribute high) with byte lane writes
// no dependencies; one byte write and one registered cell read per cycle

module mtda_vram #(
    parameter int WORDS = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic                     i_wr_lane,
    input  logic [$clog2(WORDS)-1:0] i_wr_addr,
    input  logic [7:0]               i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(WORDS)-1:0] i_rd_addr,
    output logic [15:0]              o_rd_data
);

    logic [15:0] r_mem [WORDS];
    logic [15:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            if (i_wr_lane) begin
                r_mem[i_wr_addr][15:8] <= i_wr_data;
            end else begin
                r_mem[i_wr_addr][7:0] <= i_wr_data;
            end
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/monochrome_text_display_adapter.sv */
// monochrome text display adapter top level; uses mtda_pkg, mtda_vram, mtda_ram
// a taken beat is latched and the memories read; S_EXEC loads the result register and
//   raises m_tvalid once the output is free; beats are taken only in S_IDLE, so each is
//   written back in S_EXEC (then S_MARK for a cursor location write) before the next
// reset: synchronous, active low; a clearing pass then sets every dirty mark and zeroes
//   the crt registers while s_tready stays low

module monochrome_text_display_adapter #(
    parameter int MEM_BYTES     = 4096,
    parameter int CELL_COUNT    = 2048,
    parameter int CRT_REG_COUNT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // bus_address[19:0], io_port[23:20], write_data[31:24], cell_index[42:32], zero pad
    input  logic [47:0] s_tdata,
    // func[2:0]
    input  logic [2:0]  s_tuser,
    // scan_last
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[7:0], char_code[15:8], underline[16], high_intensity[17], blink[18],
    // inverse[19], cursor_position[31:20]
    output logic [31:0] m_tdata,
    // cell_emitted
    output logic        m_tuser
);

    import mtda_pkg::*;

    localparam int MEM_W  = $clog2(MEM_BYTES);
    localparam int WORD_W = MEM_W - 1;
    localparam int WORDS  = MEM_BYTES / 2;
    localparam int CELL_W = $clog2(CELL_COUNT);
    localparam int CRT_W  = $clog2(CRT_REG_COUNT);

    // input unpacking
    logic [19:0] in_addr;
    logic [3:0]  in_port;
    logic [7:0]  in_data;
    logic [15:0] in_cell_ext;
    logic [19:0] in_slot;
    logic [15:0] in_word_ext;

    assign in_addr     = s_tdata[19:0];
    assign in_port     = s_tdata[23:20];
    assign in_data     = s_tdata[31:24];
    assign in_cell_ext = 16'(s_tdata[42:32]);
    assign in_slot     = in_addr - BASE_ADDR;
    assign in_word_ext = 16'(in_slot[MEM_W-1:1]);

    // control state
    t_state            r_state, n_state;
    logic [CELL_W-1:0] r_sweep;
    logic              r_redraw, n_redraw;
    logic              r_shown, n_shown;
    logic [CELL_W-1:0] r_cursor, n_cursor;
    logic              r_status, n_status;
    logic              r_blink_en, n_blink_en;
    logic [7:0]        r_crt_index, n_crt_index;
    logic              r_m_tvalid;
    logic [31:0]       r_m_tdata;
    logic              r_m_tuser;

    // latched item
    logic [2:0]        r_func;
    logic              r_lane;
    logic [WORD_W-1:0] r_word;
    logic [CELL_W-1:0] r_cell;
    logic [3:0]        r_port;
    logic [7:0]        r_data;
    logic              r_last;

    // fsm outputs
    logic accept;
    logic out_free;
    logic exec_fire;
    logic sweeping;
    logic marking;
    logic cursor_move;

    // memory ports
    logic              vram_we;
    logic [15:0]       vram_rd;
    logic              mark_we;
    logic [CELL_W-1:0] mark_waddr;
    logic              mark_wd;
    logic              mark_rd;
    logic              crt_we;
    logic [CRT_W-1:0]  crt_waddr;
    logic [7:0]        crt_wd;
    logic [7:0]        crt_rd;

    // result fields
    logic [7:0]  res_read;
    logic        res_emit;
    logic [7:0]  res_char;
    logic        res_ul;
    logic        res_hi;
    logic        res_blink;
    logic        res_inv;
    logic [11:0] res_pos;
    logic [7:0]  attr;
    logic        blank;
    logic [15:0] cursor_ext;

    assign out_free    = !r_m_tvalid || m_tready;
    assign cursor_move = (r_func == F_PORT_OUT) && r_port[0]
                         && ((r_crt_index == CRT_CURSOR_HI) || (r_crt_index == CRT_CURSOR_LO));
    assign cursor_ext  = 16'(r_cursor);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_sweep == CELL_W'(CELL_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = cursor_move ? S_MARK : S_IDLE;
                end
            end
            S_MARK: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb begin
        s_tready  = 1'b0;
        exec_fire = 1'b0;
        sweeping  = 1'b0;
        marking   = 1'b0;
        unique case (r_state)
            S_CLEAR: sweeping  = 1'b1;
            S_IDLE:  s_tready  = 1'b1;
            S_EXEC:  exec_fire = out_free;
            S_MARK:  marking   = 1'b1;
            default: s_tready  = 1'b0;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    mtda_vram #(
        .WORDS(WORDS)
    ) u_vram (
        .i_clk     (i_clk),
        .i_wr_en   (vram_we),
        .i_wr_lane (r_lane),
        .i_wr_addr (r_word),
        .i_wr_data (r_data),
        .i_rd_en   (accept),
        .i_rd_addr ((s_tuser == F_SCAN) ? in_cell_ext[WORD_W-1:0] : in_word_ext[WORD_W-1:0]),
        .o_rd_data (vram_rd)
    );

    mtda_ram #(
        .WIDTH(1),
        .DEPTH(CELL_COUNT)
    ) u_marks (
        .i_clk     (i_clk),
        .i_wr_en   (mark_we),
        .i_wr_addr (mark_waddr),
        .i_wr_data (mark_wd),
        .i_rd_en   (accept),
        .i_rd_addr (in_cell_ext[CELL_W-1:0]),
        .o_rd_data (mark_rd)
    );

    mtda_ram #(
        .WIDTH(8),
        .DEPTH(CRT_REG_COUNT)
    ) u_crt (
        .i_clk     (i_clk),
        .i_wr_en   (crt_we),
        .i_wr_addr (crt_waddr),
        .i_wr_data (crt_wd),
        .i_rd_en   (accept),
        .i_rd_addr (r_crt_index[CRT_W-1:0]),
        .o_rd_data (crt_rd)
    );

    assign attr  = vram_rd[15:8];
    assign blank = (attr & ATTR_MASK) == 8'h00;

    // execute: decode the read data and build the write-back; also drives the clearing pass and the cursor mark
    always_comb begin
        n_redraw    = r_redraw;
        n_shown     = r_shown;
        n_cursor    = r_cursor;
        n_status    = r_status;
        n_blink_en  = r_blink_en;
        n_crt_index = r_crt_index;
        vram_we     = 1'b0;
        mark_we     = 1'b0;
        mark_waddr  = r_cell;
        mark_wd     = 1'b0;
        crt_we      = 1'b0;
        crt_waddr   = r_crt_index[CRT_W-1:0];
        crt_wd      = r_data;
        res_read    = 8'h00;
        res_emit    = 1'b0;
        res_char    = 8'h00;
        res_ul      = 1'b0;
        res_hi      = 1'b0;
        res_blink   = 1'b0;
        res_inv     = 1'b0;
        res_pos     = 12'h000;

        if (sweeping) begin
            mark_we    = 1'b1;
            mark_waddr = r_sweep;
            mark_wd    = 1'b1;
            crt_we     = 32'(r_sweep) < CRT_REG_COUNT;
            crt_waddr  = r_sweep[CRT_W-1:0];
            crt_wd     = 8'h00;
        end

        // second mark of a cursor move, at the new location
        if (marking) begin
            mark_we    = 1'b1;
            mark_waddr = r_cursor;
            mark_wd    = 1'b1;
        end

        if (exec_fire) begin
            unique case (r_func)
                F_MEM_RD: begin
                    res_read = r_lane ? vram_rd[15:8] : vram_rd[7:0];
                end
                F_MEM_WR: begin
                    vram_we = 1'b1;
                    mark_we = 1'b1;
                    mark_wd = 1'b1;
                end
                F_PORT_IN: begin
                    if (r_port == PORT_STATUS) begin
                        n_status = !r_status;
                        res_read = r_status ? 8'h00 : STATUS_TOGGLE;
                    end else if (r_port[0]) begin
                        res_read = crt_rd;
                    end
                end
                F_PORT_OUT: begin
                    n_redraw = 1'b1;
                    if (r_port == PORT_MODE) begin
                        n_blink_en = r_data[5];
                    end else if (r_port[0]) begin
                        crt_we = 1'b1;
                        // mark the cursor cell as it stands before any move
                        if (r_crt_index == CRT_CURSOR_START) begin
                            n_shown    = r_data[5];
                            mark_we    = 1'b1;
                            mark_waddr = r_cursor;
                            mark_wd    = 1'b1;
                        end else if (r_crt_index == CRT_CURSOR_HI) begin
                            mark_we    = 1'b1;
                            mark_waddr = r_cursor;
                            mark_wd    = 1'b1;
                            n_cursor   = CELL_W'({r_data, cursor_ext[7:0]});
                        end else if (r_crt_index == CRT_CURSOR_LO) begin
                            mark_we    = 1'b1;
                            mark_waddr = r_cursor;
                            mark_wd    = 1'b1;
                            n_cursor   = CELL_W'({cursor_ext[15:8], r_data});
                        end
                    end else begin
                        n_crt_index = r_data;
                    end
                end
                F_INVAL: begin
                    n_redraw = 1'b1;
                end
                F_SCAN: begin
                    res_emit = r_redraw || mark_rd;
                    if (res_emit) begin
                        if (blank) begin
                            res_char = BLANK_CHAR;
                        end else begin
                            res_char  = vram_rd[7:0];
                            res_ul    = attr[2:0] == 3'd1;
                            res_hi    = attr[3];
                            res_blink = attr[7] && r_blink_en;
                            res_inv   = (attr & ATTR_MASK) == ATTR_INVERSE;
                        end
                        res_pos = r_shown ? cursor_ext[11:0] : CURSOR_HIDDEN;
                    end
                    // clearing an already clear mark is harmless
                    mark_we = 1'b1;
                    mark_wd = 1'b0;
                    if (r_last) begin
                        n_redraw = 1'b0;
                    end
                end
                default: begin
                    res_read = 8'h00;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_sweep     <= '0;
            r_redraw    <= 1'b1;
            r_shown     <= 1'b1;
            r_cursor    <= '0;
            r_status    <= 1'b0;
            r_blink_en  <= 1'b0;
            r_crt_index <= 8'h00;
            r_m_tvalid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_redraw    <= n_redraw;
            r_shown     <= n_shown;
            r_cursor    <= n_cursor;
            r_status    <= n_status;
            r_blink_en  <= n_blink_en;
            r_crt_index <= n_crt_index;
            if (sweeping) begin
                r_sweep <= r_sweep + 1'b1;
            end
            if (exec_fire) begin
                r_m_tvalid <= 1'b1;
            end else if (m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= s_tuser;
            r_lane <= in_slot[0];
            r_word <= in_word_ext[WORD_W-1:0];
            r_cell <= (s_tuser == F_SCAN) ? in_cell_ext[CELL_W-1:0]
                                          : in_word_ext[CELL_W-1:0];
            r_port <= in_port;
            r_data <= in_data;
            r_last <= s_tlast;
        end
        if (exec_fire) begin
            r_m_tdata <= {res_pos, res_inv, res_blink, res_hi, res_ul, res_char, res_read};
            r_m_tuser <= res_emit;
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = r_m_tdata;
    assign m_tuser  = r_m_tuser;

endmodule

/* bench/mtda_scoreboard.sv */
// result scoreboard for the monochrome text display adapter bench
// watches both stream channels, predicts every reply from its own copy of
// the adapter state and compares field by field; uses mtda_pkg

module mtda_scoreboard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // bus_address[19:0], io_port[23:20], write_data[31:24], cell_index[42:32], zero pad
    input  logic [47:0] i_s_tdata,
    // func[2:0]
    input  logic [2:0]  i_s_tuser,
    // scan_last
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // read_data[7:0], char_code[15:8], underline[16], high_intensity[17], blink[18],
    // inverse[19], cursor_position[31:20]
    input  logic [31:0] i_m_tdata,
    // cell_emitted
    input  logic        i_m_tuser,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mtda_pkg::*;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        cell_emitted;
        logic [7:0]  char_code;
        logic        underline;
        logic        high_intensity;
        logic        blink;
        logic        inverse;
        logic [11:0] cursor_position;
    } t_adapter_reply;

    // shadow of the adapter state
    logic [7:0]  vram [4096];
    logic        dirty [2048];
    logic        redraw_pending;
    logic        cursor_on;
    logic [15:0] cursor_loc;
    logic [7:0]  status_bits;
    logic [7:0]  mode_reg;
    logic [7:0]  crt_sel;
    logic [7:0]  crt_regs [256];

    t_adapter_reply replies [$];
    int mismatches = 0;

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic decode_beat(
        input  logic [2:0]  func,
        input  logic [19:0] addr,
        input  logic [3:0]  port,
        input  logic [7:0]  data,
        input  logic [10:0] cell_idx,
        input  logic        last,
        output t_adapter_reply r
    );
        logic [11:0] slot;
        logic [7:0]  ch;
        logic [7:0]  at;
        r = '0;
        slot = 12'(addr - BASE_ADDR);
        case (func)
            F_MEM_RD: r.read_data = vram[slot];
            F_MEM_WR: begin
                vram[slot] = data;
                dirty[slot[11:1]] = 1'b1;
            end
            F_PORT_IN: begin
                if (port == PORT_STATUS) begin
                    status_bits = status_bits ^ STATUS_TOGGLE;
                    r.read_data = status_bits;
                end else if (port[0]) begin
                    r.read_data = crt_regs[crt_sel];
                end
            end
            F_PORT_OUT: begin
                redraw_pending = 1'b1;
                if (port == PORT_MODE) begin
                    mode_reg = data;
                end else if (port[0]) begin
                    crt_regs[crt_sel] = data;
                    // cursor moves dirty both the old and the new cell
                    if (crt_sel == CRT_CURSOR_START) begin
                        cursor_on = data[5];
                        dirty[cursor_loc[10:0]] = 1'b1;
                    end else if (crt_sel == CRT_CURSOR_HI) begin
                        dirty[cursor_loc[10:0]] = 1'b1;
                        cursor_loc[15:8] = data;
                        dirty[cursor_loc[10:0]] = 1'b1;
                    end else if (crt_sel == CRT_CURSOR_LO) begin
                        dirty[cursor_loc[10:0]] = 1'b1;
                        cursor_loc[7:0] = data;
                        dirty[cursor_loc[10:0]] = 1'b1;
                    end
                end else begin
                    crt_sel = data;
                end
            end
            F_INVAL: redraw_pending = 1'b1;
            F_SCAN: begin
                if (redraw_pending || dirty[cell_idx]) begin
                    ch = vram[{cell_idx, 1'b0}];
                    at = vram[{cell_idx, 1'b1}];
                    r.cell_emitted = 1'b1;
                    if ((at & ATTR_MASK) == 8'h00) begin
                        r.char_code = BLANK_CHAR;
                    end else begin
                        r.char_code      = ch;
                        r.underline      = (at[2:0] == 3'd1);
                        r.high_intensity = at[3];
                        r.blink          = at[7] && mode_reg[5];
                        r.inverse        = ((at & ATTR_MASK) == ATTR_INVERSE);
                    end
                    r.cursor_position = cursor_on ? {1'b0, cursor_loc[10:0]} : CURSOR_HIDDEN;
                    dirty[cell_idx] = 1'b0;
                end
                if (last) redraw_pending = 1'b0;
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_adapter_reply want;
        if (!i_rst_n) begin
            for (int k = 0; k < 4096; k++) vram[k] = 8'h00;
            for (int k = 0; k < 2048; k++) dirty[k] = 1'b1;
            for (int k = 0; k < 256; k++) crt_regs[k] = 8'h00;
            redraw_pending = 1'b1;
            cursor_on      = 1'b1;
            cursor_loc     = 16'h0000;
            status_bits    = 8'h00;
            mode_reg       = 8'h00;
            crt_sel        = 8'h00;
            replies.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (replies.size() == 0) begin
                    $error("result beat with nothing expected: tdata %h tuser %b",
                           i_m_tdata, i_m_tuser);
                    mismatches++;
                end else begin
                    want = replies.pop_front();
                    check_field("read_data", want.read_data, i_m_tdata[7:0]);
                    check_field("cell_emitted", want.cell_emitted, i_m_tuser);
                    check_field("char_code", want.char_code, i_m_tdata[15:8]);
                    check_field("underline", want.underline, i_m_tdata[16]);
                    check_field("high_intensity", want.high_intensity, i_m_tdata[17]);
                    check_field("blink", want.blink, i_m_tdata[18]);
                    check_field("inverse", want.inverse, i_m_tdata[19]);
                    check_field("cursor_position", want.cursor_position, i_m_tdata[31:20]);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                decode_beat(i_s_tuser, i_s_tdata[19:0], i_s_tdata[23:20], i_s_tdata[31:24],
                            i_s_tdata[42:32], i_s_tlast, want);
                replies.push_back(want);
            end
        end
        o_errors  <= mismatches;
        o_pending <= replies.size();
    end

endmodule

/* bench/testbench.sv */
// top of the monochrome text display adapter bench
// drives bus, port, scan, invalidate and reserved beats with bursty timing and a stalling receiver;
// uses mtda_pkg, mtda_scoreboard and the adapter rtl

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mtda_pkg::*;

    localparam int         N_ITEMS        = 1650;
    localparam int         WATCHDOG_LIMIT = 10000;
    localparam logic [2:0] F_RSVD6        = 3'd6;
    localparam logic [2:0] F_RSVD7        = 3'd7;

    logic        i_clk;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    int fail_count;
    int beats_pending;

    // sender bookkeeping
    int beats_sent = 0;
    int burst_left = 0;
    bit written [4096];
    bit listed [2048];
    int ready_cells [$];

    // receiver stall pattern
    int rx_mode = 0;
    int rx_left = 0;
    int idle_cycles = 0;

    monochrome_text_display_adapter u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    mtda_scoreboard u_score (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .o_errors   (fail_count),
        .o_pending  (beats_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(50, 300);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom);
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (rx_left % 5 != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one beat on the input channel, followed by a gap when the burst runs out
    task automatic put(
        input logic [2:0]  f,
        input logic [19:0] a,
        input logic [3:0]  p,
        input logic [7:0]  d,
        input logic [10:0] c,
        input logic        l
    );
        int gap;
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {5'b0, c, d, p, a};
        s_tlast  <= l;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        if (f != F_RSVD6 && f != F_RSVD7) beats_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(0, 12);
        end
    endtask

    task automatic mem_write(input int slot, input logic [7:0] d);
        int cell_idx;
        cell_idx = slot / 2;
        put(F_MEM_WR, {8'($urandom), 12'(slot)}, 4'($urandom), d, 11'($urandom),
            1'($urandom));
        written[slot] = 1'b1;
        // a cell may be scanned only once both its bytes hold data
        if (written[cell_idx * 2] && written[cell_idx * 2 + 1] && !listed[cell_idx]) begin
            listed[cell_idx] = 1'b1;
            ready_cells.push_back(cell_idx);
        end
    endtask

    task automatic write_cell(input int cell_idx, input logic [7:0] ch, input logic [7:0] attr);
        mem_write(cell_idx * 2, ch);
        mem_write(cell_idx * 2 + 1, attr);
    endtask

    task automatic mem_read(input int slot);
        put(F_MEM_RD, {8'($urandom), 12'(slot)}, 4'($urandom), 8'($urandom), 11'($urandom),
            1'($urandom));
    endtask

    task automatic port_out(input logic [3:0] p, input logic [7:0] d);
        put(F_PORT_OUT, 20'($urandom), p, d, 11'($urandom), 1'($urandom));
    endtask

    task automatic port_in(input logic [3:0] p);
        put(F_PORT_IN, 20'($urandom), p, 8'($urandom), 11'($urandom), 1'($urandom));
    endtask

    task automatic scan(input int cell_idx, input logic l);
        put(F_SCAN, 20'($urandom), 4'($urandom), 8'($urandom), 11'(cell_idx), l);
    endtask

    function automatic logic [3:0] index_port();
        logic [3:0] p;
        p = {3'($urandom), 1'b0};
        return (p == PORT_MODE) ? PORT_STATUS : p;
    endfunction

    task automatic set_crt(input logic [7:0] idx, input logic [7:0] d);
        port_out(index_port(), idx);
        port_out({3'($urandom), 1'b1}, d);
    endtask

    // mostly the first and last 32 cells so that cells get revisited
    function automatic int pick_cell();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5) return $urandom_range(0, 31);
        if (roll < 9) return $urandom_range(2016, 2047);
        return $urandom_range(0, 2047);
    endfunction

    function automatic logic [7:0] rand_attr();
        case ($urandom_range(0, 15))
            0:       return 8'h00;
            1:       return 8'h08;
            2:       return 8'h80;
            3:       return 8'h88;
            4:       return 8'h70;
            5:       return 8'h78;
            6:       return 8'hF0;
            7:       return 8'hF8;
            8:       return 8'h01;
            9:       return 8'h89;
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        int n;
        int base;
        int roll;
        int sel;
        logic [7:0] hi;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: attribute corners, cursor at the last cell, status toggling
        write_cell(0, 8'h41, 8'h07);
        write_cell(1, 8'h5A, 8'h89);
        write_cell(1024, 8'h7E, 8'h88);
        write_cell(2047, 8'hFF, 8'hF8);
        port_out(PORT_MODE, 8'h20);
        port_out(4'd0, CRT_CURSOR_HI);
        port_out(4'd15, 8'hFF);
        port_out(4'd14, CRT_CURSOR_LO);
        port_out(4'd1, 8'hFF);
        port_in(PORT_STATUS);
        port_in(PORT_STATUS);
        port_in(4'd15);
        scan(2047, 1'b0);
        scan(0, 1'b0);
        scan(1, 1'b0);
        scan(1024, 1'b1);
        put(F_MEM_RD, 20'hFFFFF, 4'd0, 8'h00, 11'h7FF, 1'b1);
        // the status offset also loads the crt index; then hide the cursor
        port_out(PORT_STATUS, CRT_CURSOR_START);
        port_out(4'd11, 8'h00);
        scan(0, 1'b1);
        scan(1, 1'b0);
        put(F_INVAL, 20'h00000, 4'd0, 8'h00, 11'h000, 1'b0);
        put(F_RSVD6, 20'hFFFFF, 4'hF, 8'hFF, 11'h7FF, 1'b1);

        while (beats_sent < N_ITEMS) begin
            roll = $urandom_range(0, 19);
            n = $urandom_range(1, 8);
            if (roll < 7) begin
                // refresh pass ending on the last scan
                if ($urandom_range(0, 2) == 0) begin
                    base = pick_cell();
                    for (int i = 0; i < n; i++)
                        write_cell((base + i) % 2048, 8'($urandom), rand_attr());
                    for (int i = 0; i < n; i++) scan((base + i) % 2048, i == n - 1);
                end else begin
                    for (int i = 0; i < n; i++)
                        scan(ready_cells[$urandom_range(0, ready_cells.size() - 1)],
                             i == n - 1);
                end
            end else if (roll < 12) begin
                if ($urandom_range(0, 2) == 0)
                    mem_write(pick_cell() * 2 + $urandom_range(0, 1), 8'($urandom));
                else
                    write_cell(pick_cell(), 8'($urandom), rand_attr());
            end else if (roll < 14) begin
                mem_read(ready_cells[$urandom_range(0, ready_cells.size() - 1)] * 2 +
                         $urandom_range(0, 1));
            end else if (roll < 17) begin
                sel = $urandom_range(0, 7);
                if (sel == 0) begin
                    case ($urandom_range(0, 3))
                        0:       hi = 8'h00;
                        1:       hi = 8'h07;
                        2:       hi = 8'hF8;
                        default: hi = 8'($urandom);
                    endcase
                    set_crt(CRT_CURSOR_HI, hi);
                end else if (sel == 1) begin
                    set_crt(CRT_CURSOR_LO, 8'($urandom));
                end else if (sel == 2) begin
                    set_crt(CRT_CURSOR_START, 8'($urandom));
                end else if (sel == 3) begin
                    port_out(PORT_MODE, 8'($urandom));
                end else if (sel == 4) begin
                    port_in(PORT_STATUS);
                end else if (sel == 5) begin
                    port_in(4'($urandom));
                end else if (sel == 6) begin
                    port_out(4'($urandom), 8'($urandom));
                end else begin
                    set_crt(8'($urandom), 8'($urandom));
                    port_in({3'($urandom), 1'b1});
                end
            end else if (roll == 17) begin
                put(F_INVAL, 20'($urandom), 4'($urandom), 8'($urandom), 11'($urandom),
                    1'($urandom));
            end else if (roll == 18) begin
                put($urandom_range(0, 1) ? F_RSVD6 : F_RSVD7, 20'($urandom), 4'($urandom),
                    8'($urandom), 11'($urandom), 1'($urandom));
            end else begin
                scan(ready_cells[$urandom_range(0, ready_cells.size() - 1)], 1'($urandom));
            end
        end

        @(negedge i_clk);
        s_tvalid <= 1'b0;
        // the watchdog bounds this wait
        while (beats_pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* filelist.f */
rtl/mtda_pkg.sv
rtl/mtda_ram.sv
rtl/mtda_vram.sv
rtl/monochrome_text_display_adapter.sv
bench/mtda_scoreboard.sv
bench/testbench.sv
